>>> hw/rtl/wav_header_parser_macros.svh
// Assertion macros shared by the WAVE header parser checkers.
// Depends on nothing; take it in by include with the bare file name.
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define WHP_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define WHP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/whp_pkg.sv
// Types and constants of the WAVE header parser.
// Used by all parser modules and the checker.
`timescale 1ns / 1ps

package whp_pkg;

	// Tags, first character in the high byte; TAG_FMT holds fmt in its low bytes
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h0066_6D74;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	// Byte positions in the fixed header
	localparam logic [5:0] POS_RIFF     = 6'd3;
	localparam logic [5:0] POS_WAVE     = 6'd11;
	localparam logic [5:0] POS_FMT      = 6'd14;
	localparam logic [5:0] POS_FMT_SIZE = 6'd16;
	localparam logic [5:0] POS_CHANNELS = 6'd22;
	localparam logic [5:0] POS_RATE     = 6'd24;
	localparam logic [5:0] POS_BRATE    = 6'd28;
	localparam logic [5:0] POS_ALIGN    = 6'd32;
	localparam logic [5:0] POS_BITS     = 6'd34;
	localparam logic [5:0] POS_LAST     = 6'd38;

	localparam logic [7:0]  FMT_SIZE_OK  = 8'd16;
	localparam logic [15:0] MAX_CHANNELS = 16'd3;
	localparam logic [15:0] BITS_OK      = 16'd16;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_RIFF  = 3'd1,
		ST_NO_WAVE  = 3'd2,
		ST_NO_FMT   = 3'd3,
		ST_FMT_SIZE = 3'd4,
		ST_CHANNELS = 3'd5,
		ST_BITS     = 3'd6,
		ST_TRUNC    = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [31:0] byte_rate;
		logic [15:0] frame_bytes;
		logic [15:0] sample_bits;
		logic [31:0] data_size;
	} result_t;

endpackage

>>> hw/rtl/whp_if.sv
// Valid/ready channel interfaces of the WAVE header parser.
// Depends on nothing; the byte stream in and the header result out.
`timescale 1ns / 1ps

interface whp_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source (output valid, data_byte, first_byte, last_byte, input ready);
	modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface whp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] channel_count;
	logic [31:0] rate_hz;
	logic [31:0] byte_rate;
	logic [15:0] frame_bytes;
	logic [15:0] sample_bits;
	logic [31:0] data_size;

	modport source (output valid, status, channel_count, rate_hz, byte_rate,
		frame_bytes, sample_bits, data_size, input ready);
	modport sink (input valid, status, channel_count, rate_hz, byte_rate,
		frame_bytes, sample_bits, data_size, output ready);
endinterface

>>> hw/rtl/whp_in_reg.sv
// Input register of the WAVE header parser: holds one byte word.
// Depends on whp_pkg and whp_stream_if.
`timescale 1ns / 1ps

module whp_in_reg import whp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	whp_stream_if.sink      stream,
	input  logic            advance,
	output logic            valid_s1,
	output in_word_t        word_s1
);

	logic take;

	// Accept when empty or when the held word moves on this cycle
	assign stream.ready = !valid_s1 || advance;
	assign take = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Load the payload with each accepted word
	always_ff @(posedge clk) begin
		if (take) begin
			word_s1.data_byte  <= stream.data_byte;
			word_s1.first_byte <= stream.first_byte;
			word_s1.last_byte  <= stream.last_byte;
		end
	end

endmodule

>>> hw/rtl/whp_parse.sv
// Parse state of the WAVE header parser: header checks, field capture,
// data tag search and status decision for one word. Depends on whp_pkg.
`timescale 1ns / 1ps

module whp_parse import whp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_word_t word_s1,
	input  logic     advance,
	output logic     produce,
	output result_t  result
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_SEARCH,
		PH_SIZE,
		PH_DONE
	} phase_t;

	phase_t      phase_q, ph, ph_n;
	logic [5:0]  pos_q, pos, pos_n;
	logic [31:0] win_q, win, win_n, win_sh;
	logic [15:0] ch_q, ch, ch_n;
	logic [31:0] rate_q, rate, rate_n;
	logic [31:0] brate_q, brate, brate_n;
	logic [15:0] align_q, align, align_n;
	logic [15:0] bits_q, bits, bits_n;
	logic [31:0] size_q, size, size_n;
	logic [7:0]  b;
	logic [5:0]  lane_ch, lane_rate, lane_brate, lane_align, lane_bits;
	logic [1:0]  k;
	logic        hit, idle, full;
	status_t     st;

	// Start from cleared state on a first-byte mark
	always_comb begin
		b     = word_s1.data_byte;
		ph    = word_s1.first_byte ? PH_HEADER : phase_q;
		pos   = word_s1.first_byte ? 6'd0 : pos_q;
		win   = word_s1.first_byte ? 32'd0 : win_q;
		ch    = word_s1.first_byte ? 16'd0 : ch_q;
		rate  = word_s1.first_byte ? 32'd0 : rate_q;
		brate = word_s1.first_byte ? 32'd0 : brate_q;
		align = word_s1.first_byte ? 16'd0 : align_q;
		bits  = word_s1.first_byte ? 16'd0 : bits_q;
		size  = word_s1.first_byte ? 32'd0 : size_q;
	end

	// Byte lanes of the little-endian format fields
	assign lane_ch    = pos - POS_CHANNELS;
	assign lane_rate  = pos - POS_RATE;
	assign lane_brate = pos - POS_BRATE;
	assign lane_align = pos - POS_ALIGN;
	assign lane_bits  = pos - POS_BITS;
	assign win_sh     = {win[23:0], b};
	assign k          = pos[1:0];

	// Work out next state and the result for this word
	always_comb begin
		ph_n    = ph;
		pos_n   = pos;
		win_n   = win;
		ch_n    = ch;
		rate_n  = rate;
		brate_n = brate;
		align_n = align;
		bits_n  = bits;
		size_n  = size;
		st      = ST_OK;
		hit     = 1'b0;
		idle    = 1'b0;
		case (ph)
			PH_HEADER: begin
				win_n = win_sh;
				if (pos == POS_RIFF && win_sh != TAG_RIFF) begin
					hit = 1'b1;
					st  = ST_NO_RIFF;
				end else if (pos == POS_WAVE && win_sh != TAG_WAVE) begin
					hit = 1'b1;
					st  = ST_NO_WAVE;
				end else if (pos == POS_FMT && win_sh[23:0] != TAG_FMT[23:0]) begin
					hit = 1'b1;
					st  = ST_NO_FMT;
				end else if (pos == POS_FMT_SIZE && b != FMT_SIZE_OK) begin
					hit = 1'b1;
					st  = ST_FMT_SIZE;
				end else if (pos >= POS_CHANNELS && pos < POS_RATE) begin
					ch_n = ch | ({8'd0, b} << {lane_ch[0], 3'b000});
				end else if (pos >= POS_RATE && pos < POS_BRATE) begin
					rate_n = rate | ({24'd0, b} << {lane_rate[1:0], 3'b000});
				end else if (pos >= POS_BRATE && pos < POS_ALIGN) begin
					brate_n = brate | ({24'd0, b} << {lane_brate[1:0], 3'b000});
				end else if (pos >= POS_ALIGN && pos < POS_BITS) begin
					align_n = align | ({8'd0, b} << {lane_align[0], 3'b000});
				end else if (pos >= POS_BITS && pos < POS_BITS + 6'd2) begin
					bits_n = bits | ({8'd0, b} << {lane_bits[0], 3'b000});
				end
				if (pos >= POS_LAST) begin
					ph_n = PH_SEARCH;
				end else begin
					pos_n = pos + 6'd1;
				end
			end
			PH_SEARCH: begin
				win_n = win_sh;
				if (win_sh == TAG_DATA) begin
					ph_n  = PH_SIZE;
					pos_n = 6'd0;
				end
			end
			PH_SIZE: begin
				size_n = size | ({24'd0, b} << {k, 3'b000});
				if (k == 2'd3) begin
					hit = 1'b1;
					if (ch > MAX_CHANNELS) begin
						st = ST_CHANNELS;
					end else if (bits != BITS_OK) begin
						st = ST_BITS;
					end else begin
						st = ST_OK;
					end
				end else begin
					pos_n = {4'd0, k + 2'd1};
				end
			end
			default: begin
				idle = 1'b1;
			end
		endcase
		// Flag a file that ends before the parse finishes
		if (!idle && !hit && word_s1.last_byte) begin
			hit = 1'b1;
			st  = ST_TRUNC;
		end
		if (hit) begin
			ph_n = PH_DONE;
		end
	end

	// Fields carry captured values only for a completed parse
	assign full = (st == ST_OK) || (st == ST_CHANNELS) || (st == ST_BITS);
	assign produce = hit;
	assign result.status        = st;
	assign result.channel_count = full ? ch_n : 16'd0;
	assign result.rate_hz       = full ? rate_n : 32'd0;
	assign result.byte_rate     = full ? brate_n : 32'd0;
	assign result.frame_bytes   = full ? align_n : 16'd0;
	assign result.sample_bits   = full ? bits_n : 16'd0;
	assign result.data_size     = full ? size_n : 32'd0;

	// Advance the parse state once per consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= 6'd0;
			win_q   <= 32'd0;
			ch_q    <= 16'd0;
			rate_q  <= 32'd0;
			brate_q <= 32'd0;
			align_q <= 16'd0;
			bits_q  <= 16'd0;
			size_q  <= 32'd0;
		end else if (advance) begin
			phase_q <= ph_n;
			pos_q   <= pos_n;
			win_q   <= win_n;
			ch_q    <= ch_n;
			rate_q  <= rate_n;
			brate_q <= brate_n;
			align_q <= align_n;
			bits_q  <= bits_n;
			size_q  <= size_n;
		end
	end

endmodule

>>> hw/rtl/whp_out_reg.sv
// Result register of the WAVE header parser: holds one result word
// until the receiver takes it. Depends on whp_pkg and whp_result_if.
`timescale 1ns / 1ps

module whp_out_reg import whp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  result_t       d,
	output logic          slot_free,
	whp_result_if.source  info
);

	logic    valid_q;
	result_t data_q;

	// Free when empty or when the held word leaves this cycle
	assign slot_free = !valid_q || info.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (info.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= d;
		end
	end

	// Drive the result channel
	assign info.valid         = valid_q;
	assign info.status        = data_q.status;
	assign info.channel_count = data_q.channel_count;
	assign info.rate_hz       = data_q.rate_hz;
	assign info.byte_rate     = data_q.byte_rate;
	assign info.frame_bytes   = data_q.frame_bytes;
	assign info.sample_bits   = data_q.sample_bits;
	assign info.data_size     = data_q.data_size;

endmodule

>>> hw/rtl/wav_header_parser.sv
// WAVE header parser, top level.
// Channels: stream takes one file byte per word with first_byte and
// last_byte marks; info gives one result word per file: a status code
// and the format fields (channels, sample rate, byte rate, block align,
// bits per sample) and the data chunk size.
// Path: a byte that yields a result passes through the input register,
// then its result through the result register onto info.
// Throughput: one byte per cycle, outside the stall below. The parse
// is a single pass of short logic between input and result registers.
// Stall: bytes that yield no result keep flowing while a result waits.
// A byte that yields a result holds in the input register, and stream
// backs up, until the result register frees.
// Reset: the parse restarts at byte 0 with all captured fields zero;
// both registers empty. After a result, bytes are dropped until the next
// first_byte mark.
// Depends on whp_pkg, whp_if, whp_in_reg, whp_parse and whp_out_reg.
`timescale 1ns / 1ps

module wav_header_parser import whp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	whp_stream_if.sink   stream,
	whp_result_if.source info
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     advance;
	logic     produce;
	logic     slot_free;
	result_t  result;

	// Consume the held word unless its result has nowhere to go
	assign advance = valid_s1 && (!produce || slot_free);

	whp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	whp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_s1 (word_s1),
		.advance (advance),
		.produce (produce),
		.result  (result)
	);

	whp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && produce),
		.d         (result),
		.slot_free (slot_free),
		.info      (info)
	);

endmodule

>>> hw/rtl/whp_checker.sv
// Port-level checker of the WAVE header parser, bound to the top level.
// Depends on whp_pkg and wav_header_parser_macros.svh.
`timescale 1ns / 1ps
`include "wav_header_parser_macros.svh"

module whp_checker import whp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] channel_count,
	input logic [31:0] rate_hz,
	input logic [31:0] byte_rate,
	input logic [15:0] frame_bytes,
	input logic [15:0] sample_bits,
	input logic [31:0] data_size
);

	logic [146:0] res_word;
	logic         early_err;
	logic         fields_zero;
	logic         chan_ok;
	logic         bits_good;

	// Condense the result word for the checks below
	assign res_word = {status, channel_count, rate_hz, byte_rate, frame_bytes,
		sample_bits, data_size};
	assign early_err = status == ST_NO_RIFF || status == ST_NO_WAVE || status == ST_NO_FMT
		|| status == ST_FMT_SIZE || status == ST_TRUNC;
	assign fields_zero = channel_count == 16'd0 && rate_hz == 32'd0 && byte_rate == 32'd0
		&& frame_bytes == 16'd0 && sample_bits == 16'd0 && data_size == 32'd0;
	assign chan_ok   = channel_count <= MAX_CHANNELS;
	assign bits_good = sample_bits == BITS_OK;

	// A stalled result word stays put
	`WHP_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(res_word), "stalled result changed")

	// Early errors and truncation carry zero fields
	`WHP_ASSERT_NOW(a_zero_fields, clk, arst_n, out_valid && early_err, fields_zero, "error result carries nonzero fields")

	// Channel count decides the channel error
	`WHP_ASSERT_NOW(a_channels, clk, arst_n, out_valid && status == ST_CHANNELS, !chan_ok, "channel error, legal count")

	// Bit depth error only after the channel test passed
	`WHP_ASSERT_NOW(a_bits, clk, arst_n, out_valid && status == ST_BITS, chan_ok && !bits_good, "bit depth error mismatch")

	// A good header has legal channels and 16-bit samples
	`WHP_ASSERT_NOW(a_ok, clk, arst_n, out_valid && status == ST_OK, chan_ok && bits_good, "ok status, illegal fields")

endmodule

bind wav_header_parser whp_checker u_whp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (info.valid),
	.out_ready     (info.ready),
	.status        (info.status),
	.channel_count (info.channel_count),
	.rate_hz       (info.rate_hz),
	.byte_rate     (info.byte_rate),
	.frame_bytes   (info.frame_bytes),
	.sample_bits   (info.sample_bits),
	.data_size     (info.data_size)
);
